/* sv/tis_pkg.sv */
// Package for the Tomasulo issue scheduler: beat types, opcode and class codes,
// unit phase codes and the instruction decode functions. No dependencies.
package tis_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int CLS_W       = 2;
    localparam int SUB_W       = 2;   // holds a station or unit number within one class
    localparam int LAT_W       = 8;
    localparam int CYC_W       = 32;
    localparam int ADDR_W      = 16;
    localparam int REG_W       = 3;
    localparam int OP_W        = 5;
    localparam int CFG_IDX_W   = 3;

    localparam int DEF_STATIONS_PER_CLASS = 2;
    localparam int DEF_UNITS_PER_CLASS    = 2;

    localparam logic [CLS_W-1:0] CLS_INT = 2'd0;
    localparam logic [CLS_W-1:0] CLS_DIV = 2'd1;
    localparam logic [CLS_W-1:0] CLS_MUL = 2'd2;
    localparam logic [CLS_W-1:0] CLS_LS  = 2'd3;

    localparam logic [OP_W-1:0] OP_ALU_LAST = 5'b00111;
    localparam logic [OP_W-1:0] OP_DIV      = 5'b00100;
    localparam logic [OP_W-1:0] OP_MUL      = 5'b00101;
    localparam logic [OP_W-1:0] OP_DIVU     = 5'b00110;
    localparam logic [OP_W-1:0] OP_REM      = 5'b00111;
    localparam logic [OP_W-1:0] OP_LOAD     = 5'b01000;
    localparam logic [OP_W-1:0] OP_STORE    = 5'b01001;
    localparam logic [OP_W-1:0] OP_JR       = 5'b01110;
    localparam logic [OP_W-1:0] OP_LI_FIRST = 5'b10000;
    localparam logic [OP_W-1:0] OP_LI_LAST  = 5'b10010;

    localparam logic [CFG_IDX_W-1:0] CFG_INT_LAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIV_LAT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MUL_LAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LAT = 3'd3;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_ISSUED = 2'd1;
    localparam logic [1:0] PH_EXEC   = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    typedef struct packed {
        logic        instr_valid;
        logic [15:0] instr_word;
        logic [15:0] access_address;
        logic        memory_done;
    } tis_in_t;

    typedef struct packed {
        logic        issued;
        logic        stalled;
        logic [4:0]  register_reads;
        logic [3:0]  broadcasts;
        logic [1:0]  request_kind;
        logic [15:0] request_address;
        logic [1:0]  request_count;
        logic        all_idle;
    } tis_out_t;

    typedef struct packed {
        logic [REG_W-1:0] src0;
        logic [REG_W-1:0] src1;
        logic [REG_W-1:0] dest;
        logic             has_src0;
        logic             has_src1;
        logic             has_dest;
        logic             is_store;
    } tis_dec_t;

    // One station RAM entry: everything fixed at issue.
    typedef struct packed {
        tis_dec_t          dec;
        logic [CYC_W-1:0]  issue_cycle;
        logic [ADDR_W-1:0] address;
    } tis_entry_t;

    typedef logic [NUM_CLASSES-1:0][LAT_W-1:0] tis_lat_vec_t;

    function automatic logic [CLS_W-1:0] tis_class(input logic [OP_W-1:0] op);
        logic [CLS_W-1:0] cls;
        cls = CLS_INT;
        if (op == OP_LOAD || op == OP_STORE) begin
            cls = CLS_LS;
        end else if (op == OP_MUL) begin
            cls = CLS_MUL;
        end else if (op == OP_DIV || op == OP_DIVU || op == OP_REM) begin
            cls = CLS_DIV;
        end
        return cls;
    endfunction

    function automatic tis_dec_t tis_decode(input logic [15:0] word);
        tis_dec_t        d;
        logic [OP_W-1:0] op;
        op         = word[15:11];
        d.dest     = word[10:8];
        d.src0     = word[7:5];
        d.src1     = word[4:2];
        d.has_src0 = 1'b0;
        d.has_src1 = 1'b0;
        d.has_dest = 1'b0;
        d.is_store = 1'b0;
        if (op <= OP_ALU_LAST) begin
            d.has_src0 = 1'b1;
            d.has_src1 = 1'b1;
            d.has_dest = 1'b1;
        end else if (op == OP_LOAD) begin
            d.has_src0 = 1'b1;
            d.has_dest = 1'b1;
        end else if (op == OP_STORE) begin
            d.has_src0 = 1'b1;
            d.has_src1 = 1'b1;
            d.is_store = 1'b1;
        end else if (op >= OP_LI_FIRST && op <= OP_LI_LAST) begin
            d.has_dest = 1'b1;
        end else if (op == OP_JR) begin
            d.has_src0 = 1'b1;
        end
        return d;
    endfunction

endpackage

/* sv/tis_sched_core.sv */
// Scheduler sequencer: station RAM with one registered read port, station and
// unit control flops, and the per-tick walk over them. Depends on tis_pkg.
module tis_sched_core #(
    parameter int STATIONS_PER_CLASS = tis_pkg::DEF_STATIONS_PER_CLASS,
    parameter int UNITS_PER_CLASS    = tis_pkg::DEF_UNITS_PER_CLASS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  tis_pkg::tis_in_t      item,
    input  tis_pkg::tis_lat_vec_t latencies,
    input  logic                  out_ready,
    output logic                  idle,
    output logic                  done,
    output tis_pkg::tis_out_t     result
);
    import tis_pkg::*;

    localparam int NS    = NUM_CLASSES * STATIONS_PER_CLASS;
    localparam int NU    = NUM_CLASSES * UNITS_PER_CLASS;
    localparam int SI_W  = $clog2(NS);
    localparam int UI_W  = $clog2(NU);
    localparam int TAG_W = $clog2(NS + 1);
    localparam int RD_W  = $clog2(2 * NS + 1);
    localparam int BC_W  = $clog2(NU + 1);
    localparam int RC_W  = $clog2(UNITS_PER_CLASS + 1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ISSUE   = 4'd1;
    localparam logic [3:0] ST_MARK_RD = 4'd2;
    localparam logic [3:0] ST_MARK_PR = 4'd3;
    localparam logic [3:0] ST_REN_RD  = 4'd4;
    localparam logic [3:0] ST_REN_PR  = 4'd5;
    localparam logic [3:0] ST_EXE_RD  = 4'd6;
    localparam logic [3:0] ST_EXE_PR  = 4'd7;
    localparam logic [3:0] ST_WB_RD   = 4'd8;
    localparam logic [3:0] ST_WB_PR   = 4'd9;
    localparam logic [3:0] ST_DONE    = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [CLS_W-1:0] cls_reg, cls_next;
    logic [SUB_W-1:0] sub_reg, sub_next;
    logic [CYC_W-1:0] cycle_reg, cycle_next;
    logic             mem_busy_reg, mem_busy_next;
    tis_in_t          item_reg, item_next;

    logic [TAG_W-1:0] reg_tag_reg [8];
    logic [TAG_W-1:0] reg_tag_next [8];

    logic [NS-1:0]      st_busy_reg, st_busy_next;
    logic [NS-1:0]      st_got_reg, st_got_next;
    logic [NS-1:0]      st_first_reg, st_first_next;
    logic [NS-1:0]      st_reading_reg, st_reading_next;
    logic [NS-1:0]      st_renamed_reg, st_renamed_next;
    logic [NS-1:0][1:0] st_avail_reg, st_avail_next;
    logic [TAG_W-1:0]   st_tag_reg [NS][2];
    logic [TAG_W-1:0]   st_tag_next [NS][2];

    logic [NU-1:0]    un_busy_reg, un_busy_next;
    logic [NU-1:0]    un_ready_reg, un_ready_next;
    logic [1:0]       un_phase_reg [NU];
    logic [1:0]       un_phase_next [NU];
    logic [LAT_W-1:0] un_count_reg [NU];
    logic [LAT_W-1:0] un_count_next [NU];
    logic [SI_W-1:0]  un_station_reg [NU];
    logic [SI_W-1:0]  un_station_next [NU];

    logic              oldest_valid_reg, oldest_valid_next;
    logic [SUB_W-1:0]  oldest_sub_reg, oldest_sub_next;
    logic [CYC_W-1:0]  best_age_reg, best_age_next;

    logic              issued_reg, issued_next;
    logic              stalled_reg, stalled_next;
    logic [RD_W-1:0]   reads_reg, reads_next;
    logic [BC_W-1:0]   bcast_reg, bcast_next;
    logic [1:0]        kind_reg, kind_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [RC_W-1:0]   rcount_reg, rcount_next;

    // Station RAM
    tis_entry_t       st_mem [NS];
    tis_entry_t       rd_data_reg;
    logic             mem_we;
    logic [SI_W-1:0]  mem_wa;
    tis_entry_t       mem_wd;
    logic [SI_W-1:0]  mem_ra;

    logic [SI_W-1:0]  st_idx;
    logic [UI_W-1:0]  un_idx;
    logic             last_st_sub;
    logic             last_un_sub;

    assign st_idx = SI_W'(int'(cls_reg) * STATIONS_PER_CLASS + int'(sub_reg));
    assign un_idx = UI_W'(int'(cls_reg) * UNITS_PER_CLASS + int'(sub_reg));
    assign last_st_sub = (sub_reg == SUB_W'(STATIONS_PER_CLASS - 1));
    assign last_un_sub = (sub_reg == SUB_W'(UNITS_PER_CLASS - 1));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            st_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= st_mem[mem_ra];
    end

    always_comb begin
        tis_dec_t          dec;
        logic [CLS_W-1:0]  icls;
        logic              found;
        logic [SI_W-1:0]   si;
        logic [UI_W-1:0]   ui;
        logic              ov;
        logic [SUB_W-1:0]  osub;
        logic [CYC_W-1:0]  best;
        logic [CYC_W-1:0]  age;
        logic              a0;
        logic              a1;
        logic [TAG_W-1:0]  t0;
        logic [TAG_W-1:0]  t1;
        logic [RD_W-1:0]   radd;
        logic [LAT_W-1:0]  lat;
        logic [LAT_W-1:0]  cnt;
        logic [SI_W-1:0]   sid;
        logic [TAG_W-1:0]  tagv;

        dec   = '0;
        icls  = CLS_INT;
        found = 1'b0;
        si    = '0;
        ui    = '0;
        ov    = 1'b0;
        osub  = '0;
        best  = '0;
        age   = '0;
        a0    = 1'b0;
        a1    = 1'b0;
        t0    = '0;
        t1    = '0;
        radd  = '0;
        lat   = '0;
        cnt   = '0;
        sid   = '0;
        tagv  = '0;

        state_next        = state_reg;
        cls_next          = cls_reg;
        sub_next          = sub_reg;
        cycle_next        = cycle_reg;
        mem_busy_next     = mem_busy_reg;
        item_next         = item_reg;
        reg_tag_next      = reg_tag_reg;
        st_busy_next      = st_busy_reg;
        st_got_next       = st_got_reg;
        st_first_next     = st_first_reg;
        st_reading_next   = st_reading_reg;
        st_renamed_next   = st_renamed_reg;
        st_avail_next     = st_avail_reg;
        st_tag_next       = st_tag_reg;
        un_busy_next      = un_busy_reg;
        un_ready_next     = un_ready_reg;
        un_phase_next     = un_phase_reg;
        un_count_next     = un_count_reg;
        un_station_next   = un_station_reg;
        oldest_valid_next = oldest_valid_reg;
        oldest_sub_next   = oldest_sub_reg;
        best_age_next     = best_age_reg;
        issued_next       = issued_reg;
        stalled_next      = stalled_reg;
        reads_next        = reads_reg;
        bcast_next        = bcast_reg;
        kind_next         = kind_reg;
        addr_next         = addr_reg;
        rcount_next       = rcount_reg;
        mem_we            = 1'b0;
        mem_wa            = '0;
        mem_wd            = '0;
        mem_ra            = '0;
        done              = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    item_next    = item;
                    cycle_next   = cycle_reg + 1'b1;
                    if (item.memory_done) begin
                        mem_busy_next = 1'b0;
                    end
                    issued_next  = 1'b0;
                    stalled_next = 1'b0;
                    reads_next   = '0;
                    bcast_next   = '0;
                    kind_next    = REQ_NONE;
                    addr_next    = '0;
                    rcount_next  = '0;
                    state_next   = ST_ISSUE;
                end
            end

            ST_ISSUE: begin
                dec  = tis_decode(item_reg.instr_word);
                icls = tis_class(item_reg.instr_word[15:11]);
                if (item_reg.instr_valid) begin
                    stalled_next = 1'b1;
                    for (int k = 0; k < STATIONS_PER_CLASS; k++) begin
                        if (!found) begin
                            si = SI_W'(int'(icls) * STATIONS_PER_CLASS + k);
                            if (!st_busy_reg[si]) begin
                                found               = 1'b1;
                                mem_we              = 1'b1;
                                mem_wa              = si;
                                mem_wd.dec          = dec;
                                mem_wd.issue_cycle  = cycle_reg;
                                mem_wd.address      = item_reg.access_address;
                                st_busy_next[si]    = 1'b1;
                                st_got_next[si]     = 1'b0;
                                st_first_next[si]   = 1'b0;
                                st_reading_next[si] = 1'b0;
                                st_renamed_next[si] = 1'b0;
                                st_avail_next[si]   = 2'b00;
                                issued_next         = 1'b1;
                                stalled_next        = 1'b0;
                            end
                        end
                    end
                end
                sub_next          = '0;
                oldest_valid_next = 1'b0;
                state_next        = ST_MARK_RD;
            end

            ST_MARK_RD: begin
                mem_ra     = SI_W'(int'(CLS_LS) * STATIONS_PER_CLASS + int'(sub_reg));
                state_next = ST_MARK_PR;
            end

            ST_MARK_PR: begin
                si   = SI_W'(int'(CLS_LS) * STATIONS_PER_CLASS + int'(sub_reg));
                ov   = oldest_valid_reg;
                osub = oldest_sub_reg;
                best = best_age_reg;
                if (st_busy_reg[si] && !st_got_reg[si]) begin
                    // wrap-safe age; strict compare keeps the lowest index on a tie
                    age = cycle_reg - rd_data_reg.issue_cycle;
                    if (!ov || age > best) begin
                        ov   = 1'b1;
                        osub = sub_reg;
                        best = age;
                    end
                end
                oldest_valid_next = ov;
                oldest_sub_next   = osub;
                best_age_next     = best;
                if (last_st_sub) begin
                    if (ov) begin
                        st_first_next[SI_W'(int'(CLS_LS) * STATIONS_PER_CLASS + int'(osub))] = 1'b1;
                    end
                    cls_next   = CLS_INT;
                    sub_next   = '0;
                    state_next = ST_REN_RD;
                end else begin
                    sub_next   = sub_reg + 1'b1;
                    state_next = ST_MARK_RD;
                end
            end

            ST_REN_RD: begin
                mem_ra     = st_idx;
                state_next = ST_REN_PR;
            end

            ST_REN_PR: begin
                if (st_busy_reg[st_idx] && !st_got_reg[st_idx]) begin
                    if (!st_reading_reg[st_idx]) begin
                        st_reading_next[st_idx] = 1'b1;
                    end else begin
                        a0 = st_avail_reg[st_idx][0];
                        a1 = st_avail_reg[st_idx][1];
                        if (!st_renamed_reg[st_idx]) begin
                            // sources capture their tags before the destination is renamed
                            radd = '0;
                            if (rd_data_reg.dec.has_src0) begin
                                t0 = reg_tag_reg[rd_data_reg.dec.src0];
                                st_tag_next[st_idx][0] = t0;
                                a0   = (t0 == '0);
                                radd = radd + 1'b1;
                            end else begin
                                a0 = 1'b1;
                            end
                            if (rd_data_reg.dec.has_src1) begin
                                t1 = reg_tag_reg[rd_data_reg.dec.src1];
                                st_tag_next[st_idx][1] = t1;
                                a1   = (t1 == '0);
                                radd = radd + 1'b1;
                            end else begin
                                a1 = 1'b1;
                            end
                            reads_next = reads_reg + radd;
                            if (rd_data_reg.dec.has_dest) begin
                                reg_tag_next[rd_data_reg.dec.dest] = TAG_W'(st_idx) + 1'b1;
                            end
                            st_renamed_next[st_idx] = 1'b1;
                            st_avail_next[st_idx]   = {a1, a0};
                        end
                        if (a0 && a1 && (cls_reg != CLS_LS || st_first_reg[st_idx])) begin
                            for (int j = 0; j < UNITS_PER_CLASS; j++) begin
                                if (!found) begin
                                    ui = UI_W'(int'(cls_reg) * UNITS_PER_CLASS + j);
                                    if (!un_busy_reg[ui]) begin
                                        found               = 1'b1;
                                        un_busy_next[ui]    = 1'b1;
                                        un_ready_next[ui]   = 1'b0;
                                        un_phase_next[ui]   = PH_ISSUED;
                                        un_count_next[ui]   = '0;
                                        un_station_next[ui] = st_idx;
                                        st_got_next[st_idx] = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                if (last_st_sub) begin
                    sub_next = '0;
                    if (cls_reg == CLS_LS) begin
                        cls_next   = CLS_INT;
                        state_next = ST_EXE_RD;
                    end else begin
                        cls_next   = cls_reg + 1'b1;
                        state_next = ST_REN_RD;
                    end
                end else begin
                    sub_next   = sub_reg + 1'b1;
                    state_next = ST_REN_RD;
                end
            end

            ST_EXE_RD: begin
                mem_ra     = un_station_reg[un_idx];
                state_next = ST_EXE_PR;
            end

            ST_EXE_PR: begin
                if (un_busy_reg[un_idx] && !un_ready_reg[un_idx]) begin
                    if (un_phase_reg[un_idx] == PH_ISSUED) begin
                        un_phase_next[un_idx] = PH_EXEC;
                    end else if (un_phase_reg[un_idx] == PH_EXEC) begin
                        lat = latencies[cls_reg];
                        if (lat == '0) begin
                            lat = LAT_W'(1);
                        end
                        cnt = un_count_reg[un_idx];
                        if (cnt != '1) begin
                            cnt = cnt + 1'b1;
                        end
                        un_count_next[un_idx] = cnt;
                        if (cnt >= lat) begin
                            un_ready_next[un_idx] = 1'b1;
                            if (cls_reg == CLS_LS) begin
                                if (rcount_reg == '0) begin
                                    kind_next = rd_data_reg.dec.is_store ? REQ_WRITE : REQ_READ;
                                    addr_next = rd_data_reg.address;
                                end
                                rcount_next   = rcount_reg + 1'b1;
                                mem_busy_next = 1'b1;
                            end
                        end
                    end
                end
                if (last_un_sub) begin
                    sub_next = '0;
                    if (cls_reg == CLS_LS) begin
                        cls_next   = CLS_INT;
                        state_next = ST_WB_RD;
                    end else begin
                        cls_next   = cls_reg + 1'b1;
                        state_next = ST_EXE_RD;
                    end
                end else begin
                    sub_next   = sub_reg + 1'b1;
                    state_next = ST_EXE_RD;
                end
            end

            ST_WB_RD: begin
                mem_ra     = un_station_reg[un_idx];
                state_next = ST_WB_PR;
            end

            ST_WB_PR: begin
                if (un_ready_reg[un_idx]) begin
                    if (un_phase_reg[un_idx] == PH_EXEC) begin
                        un_phase_next[un_idx] = PH_DONE;
                    end else if (un_phase_reg[un_idx] == PH_DONE &&
                                 !(cls_reg == CLS_LS && mem_busy_reg)) begin
                        sid  = un_station_reg[un_idx];
                        tagv = TAG_W'(sid) + 1'b1;
                        un_busy_next[un_idx]  = 1'b0;
                        un_ready_next[un_idx] = 1'b0;
                        un_phase_next[un_idx] = PH_IDLE;
                        st_busy_next[sid]     = 1'b0;
                        st_got_next[sid]      = 1'b0;
                        st_first_next[sid]    = 1'b0;
                        bcast_next            = bcast_reg + 1'b1;
                        if (rd_data_reg.dec.has_dest) begin
                            // wake every renamed waiter on this tag
                            for (int j = 0; j < NS; j++) begin
                                if (st_busy_reg[j] && !st_got_reg[j] && st_renamed_reg[j]) begin
                                    for (int k = 0; k < 2; k++) begin
                                        if (!st_avail_reg[j][k] && st_tag_reg[j][k] == tagv) begin
                                            st_avail_next[j][k] = 1'b1;
                                        end
                                    end
                                end
                            end
                            if (reg_tag_reg[rd_data_reg.dec.dest] == tagv) begin
                                reg_tag_next[rd_data_reg.dec.dest] = '0;
                            end
                        end
                    end
                end
                if (last_un_sub) begin
                    sub_next = '0;
                    if (cls_reg == CLS_LS) begin
                        cls_next   = CLS_INT;
                        state_next = ST_DONE;
                    end else begin
                        cls_next   = cls_reg + 1'b1;
                        state_next = ST_WB_RD;
                    end
                end else begin
                    sub_next   = sub_reg + 1'b1;
                    state_next = ST_WB_RD;
                end
            end

            ST_DONE: begin
                // hold until the output register can take the beat
                if (out_ready) begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cls_reg        <= CLS_INT;
            sub_reg        <= '0;
            cycle_reg      <= '0;
            mem_busy_reg   <= 1'b0;
            st_busy_reg    <= '0;
            st_got_reg     <= '0;
            st_first_reg   <= '0;
            st_reading_reg <= '0;
            st_renamed_reg <= '0;
            st_avail_reg   <= '0;
            un_busy_reg    <= '0;
            un_ready_reg   <= '0;
            for (int r = 0; r < 8; r++) begin
                reg_tag_reg[r] <= '0;
            end
            for (int u = 0; u < NU; u++) begin
                un_phase_reg[u] <= PH_IDLE;
            end
        end else begin
            state_reg      <= state_next;
            cls_reg        <= cls_next;
            sub_reg        <= sub_next;
            cycle_reg      <= cycle_next;
            mem_busy_reg   <= mem_busy_next;
            st_busy_reg    <= st_busy_next;
            st_got_reg     <= st_got_next;
            st_first_reg   <= st_first_next;
            st_reading_reg <= st_reading_next;
            st_renamed_reg <= st_renamed_next;
            st_avail_reg   <= st_avail_next;
            un_busy_reg    <= un_busy_next;
            un_ready_reg   <= un_ready_next;
            reg_tag_reg    <= reg_tag_next;
            un_phase_reg   <= un_phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg         <= item_next;
        st_tag_reg       <= st_tag_next;
        un_count_reg     <= un_count_next;
        un_station_reg   <= un_station_next;
        oldest_valid_reg <= oldest_valid_next;
        oldest_sub_reg   <= oldest_sub_next;
        best_age_reg     <= best_age_next;
        issued_reg       <= issued_next;
        stalled_reg      <= stalled_next;
        reads_reg        <= reads_next;
        bcast_reg        <= bcast_next;
        kind_reg         <= kind_next;
        addr_reg         <= addr_next;
        rcount_reg       <= rcount_next;
    end

    assign idle = (state_reg == ST_IDLE);

    always_comb begin
        result.issued          = issued_reg;
        result.stalled         = stalled_reg;
        result.register_reads  = 5'(reads_reg);
        result.broadcasts      = 4'(bcast_reg);
        result.request_kind    = kind_reg;
        result.request_address = addr_reg;
        result.request_count   = 2'(rcount_reg);
        result.all_idle        = !mem_busy_reg && (st_busy_reg == '0);
    end

    // Assertions
    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && !start) |=> (state_reg == ST_IDLE))
        else $error("sequencer left idle without a start");

    a_done_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> (state_reg == ST_IDLE && $past(state_reg) == ST_DONE))
        else $error("result beat not followed by idle");

    for (genvar r = 0; r < 8; r++) begin : g_tag_chk
        a_tag_owner: assert property (@(posedge aclk) disable iff (!aresetn)
            (state_reg == ST_IDLE && reg_tag_reg[r] != '0)
            |-> st_busy_reg[SI_W'(reg_tag_reg[r] - 1'b1)])
            else $error("register tag names a free station");
    end

    for (genvar u = 0; u < NU; u++) begin : g_unit_chk
        a_unit_owner: assert property (@(posedge aclk) disable iff (!aresetn)
            (state_reg == ST_IDLE && un_busy_reg[u])
            |-> (st_busy_reg[un_station_reg[u]] && st_got_reg[un_station_reg[u]]))
            else $error("busy unit holds a station that does not own it");
    end

endmodule

/* sv/tomasulo_issue_scheduler.sv */
// Top level of the Tomasulo issue scheduler: latency registers, input handshake
// and result register. Depends on tis_pkg and tis_sched_core.
//
// Each input beat is one clock tick of a Tomasulo timing model and yields one
// result beat. A tick is handled by a sequencer that walks the load/store
// stations, then every station, then every unit in an execute and a writeback
// pass, all through the single read port of the station RAM, with one read
// state and one update state per entry. A finished result sits in its own
// register, so the next tick is taken while that beat waits. The latency
// registers are written only while the sequencer is idle; cfg_ready is low
// during a tick.
module tomasulo_issue_scheduler #(
    parameter int STATIONS_PER_CLASS = tis_pkg::DEF_STATIONS_PER_CLASS,
    parameter int UNITS_PER_CLASS    = tis_pkg::DEF_UNITS_PER_CLASS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tis_pkg::tis_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tis_pkg::tis_out_t                m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tis_pkg::LAT_W-1:0]        cfg_data
);
    import tis_pkg::*;

    tis_lat_vec_t lat_reg, lat_next;
    logic         m_valid_reg, m_valid_next;
    tis_out_t     m_data_reg;
    logic         core_idle;
    logic         core_done;
    logic         out_ready;
    tis_out_t     core_result;

    assign cfg_ready = core_idle;
    assign s_ready   = core_idle;
    assign out_ready = !m_valid_reg || m_ready;

    always_comb begin
        lat_next = lat_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_INT_LAT: lat_next[CLS_INT] = cfg_data;
                CFG_DIV_LAT: lat_next[CLS_DIV] = cfg_data;
                CFG_MUL_LAT: lat_next[CLS_MUL] = cfg_data;
                CFG_MEM_LAT: lat_next[CLS_LS]  = cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (core_done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                lat_reg[c] <= LAT_W'(1);
            end
            m_valid_reg <= 1'b0;
        end else begin
            lat_reg     <= lat_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_done) begin
            m_data_reg <= core_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    tis_sched_core #(
        .STATIONS_PER_CLASS (STATIONS_PER_CLASS),
        .UNITS_PER_CLASS    (UNITS_PER_CLASS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid && core_idle),
        .item      (s_data),
        .latencies (lat_reg),
        .out_ready (out_ready),
        .idle      (core_idle),
        .done      (core_done),
        .result    (core_result)
    );

endmodule

/* verif/tb_tomasulo_issue_scheduler.sv */
// Testbench for tomasulo_issue_scheduler: random and directed clock ticks, with
// a cycle-level scheduling model in a scoreboard class. Depends on tis_pkg and tomasulo_issue_scheduler.
module tb_tomasulo_issue_scheduler;
    timeunit 1ns;
    timeprecision 1ps;
    import tis_pkg::*;

    localparam int SPC = 2;
    localparam int UPC = 2;
    localparam int NST = NUM_CLASSES * SPC;
    localparam int NUN = NUM_CLASSES * UPC;

    class tick_scoreboard;
        typedef struct {
            bit              busy, got_unit, first, reading, renamed;
            bit              has_src[2], avail[2];
            bit [2:0]        src_reg[2];
            bit [3:0]        src_tag[2];
            bit              has_dest, is_store;
            bit [2:0]        dest;
            bit [31:0]       issue_cycle;
            bit [15:0]       address;
        } rs_entry_t;
        typedef struct {
            bit       busy, ready;
            bit [1:0] phase;
            bit [7:0] count;
            bit [2:0] station;
        } fu_entry_t;

        bit [7:0]   lat[4];
        bit [3:0]   reg_tag[8];
        rs_entry_t  rs[NST];
        fu_entry_t  fu[NUN];
        bit         mem_busy;
        bit [31:0]  cycles;
        tis_out_t   expected_ticks[$];
        int         mismatches;

        function new();
            rs_entry_t z;
            fu_entry_t zu;
            foreach (lat[i]) lat[i] = 8'd1;
            foreach (reg_tag[i]) reg_tag[i] = '0;
            z = '{default: '0};
            zu = '{default: '0};
            foreach (rs[i]) rs[i] = z;
            foreach (fu[i]) fu[i] = zu;
            mem_busy = 0;
            cycles = 0;
            mismatches = 0;
        endfunction

        function void write_latency(bit [CFG_IDX_W-1:0] idx, bit [7:0] val);
            if (idx <= CFG_MEM_LAT) lat[idx] = val;
        endfunction

        function bit [1:0] class_of(bit [4:0] op);
            if (op == OP_LOAD || op == OP_STORE) return CLS_LS;
            if (op == OP_MUL) return CLS_MUL;
            if (op == OP_DIV || op == OP_DIVU || op == OP_REM) return CLS_DIV;
            return CLS_INT;
        endfunction

        // Advance the model by one tick and queue the result it predicts.
        function void note_input(tis_in_t it);
            tis_out_t  o;
            bit [4:0]  op;
            bit [1:0]  cls;
            int        oldest, sid, li;
            bit [31:0] best, age;
            rs_entry_t z;
            o = '0;
            z = '{default: '0};
            oldest = -1;
            best = 0;
            cycles++;
            if (it.memory_done) mem_busy = 0;

            if (it.instr_valid) begin
                op = it.instr_word[15:11];
                cls = class_of(op);
                o.stalled = 1;
                for (int i = 0; i < SPC; i++) begin
                    sid = cls * SPC + i;
                    if (!rs[sid].busy) begin
                        rs[sid] = z;
                        rs[sid].src_reg[0] = it.instr_word[7:5];
                        rs[sid].src_reg[1] = it.instr_word[4:2];
                        rs[sid].dest = it.instr_word[10:8];
                        if (op <= OP_ALU_LAST) begin
                            rs[sid].has_src = '{1, 1};
                            rs[sid].has_dest = 1;
                        end else if (op == OP_LOAD) begin
                            rs[sid].has_src[0] = 1;
                            rs[sid].has_dest = 1;
                        end else if (op == OP_STORE) begin
                            rs[sid].has_src = '{1, 1};
                            rs[sid].is_store = 1;
                        end else if (op >= OP_LI_FIRST && op <= OP_LI_LAST) begin
                            rs[sid].has_dest = 1;
                        end else if (op == OP_JR) begin
                            rs[sid].has_src[0] = 1;
                        end
                        rs[sid].busy = 1;
                        rs[sid].issue_cycle = cycles;
                        rs[sid].address = it.access_address;
                        o.issued = 1;
                        o.stalled = 0;
                        break;
                    end
                end
            end

            for (int i = CLS_LS * SPC; i < NST; i++) begin
                if (rs[i].busy && !rs[i].got_unit) begin
                    age = cycles - rs[i].issue_cycle;
                    if (oldest < 0 || age > best) begin
                        oldest = i;
                        best = age;
                    end
                end
            end
            if (oldest >= 0) rs[oldest].first = 1;

            for (int i = 0; i < NST; i++) begin
                cls = 2'(i / SPC);
                if (!rs[i].busy || rs[i].got_unit) continue;
                if (!rs[i].reading) begin
                    rs[i].reading = 1;
                    continue;
                end
                if (!rs[i].renamed) begin
                    for (int k = 0; k < 2; k++) begin
                        if (rs[i].has_src[k]) begin
                            rs[i].src_tag[k] = reg_tag[rs[i].src_reg[k]];
                            rs[i].avail[k] = (rs[i].src_tag[k] == 0);
                            o.register_reads++;
                        end else begin
                            rs[i].avail[k] = 1;
                        end
                    end
                    if (rs[i].has_dest) reg_tag[rs[i].dest] = 4'(i + 1);
                    rs[i].renamed = 1;
                end
                if (rs[i].avail[0] && rs[i].avail[1] && (cls != CLS_LS || rs[i].first)) begin
                    for (int j = 0; j < UPC; j++) begin
                        li = cls * UPC + j;
                        if (!fu[li].busy) begin
                            fu[li].busy = 1;
                            fu[li].ready = 0;
                            fu[li].phase = PH_ISSUED;
                            fu[li].count = 0;
                            fu[li].station = 3'(i);
                            rs[i].got_unit = 1;
                            break;
                        end
                    end
                end
            end

            for (int i = 0; i < NUN; i++) begin
                bit [7:0] l;
                cls = 2'(i / UPC);
                if (!fu[i].busy || fu[i].ready) continue;
                if (fu[i].phase == PH_ISSUED) begin
                    fu[i].phase = PH_EXEC;
                    continue;
                end
                if (fu[i].phase != PH_EXEC) continue;
                l = (lat[cls] == 0) ? 8'd1 : lat[cls];
                if (fu[i].count < 8'd255) fu[i].count++;
                if (fu[i].count >= l) begin
                    fu[i].ready = 1;
                    if (cls == CLS_LS) begin
                        if (o.request_count == 0) begin
                            o.request_kind = rs[fu[i].station].is_store ? REQ_WRITE : REQ_READ;
                            o.request_address = rs[fu[i].station].address;
                        end
                        o.request_count++;
                        mem_busy = 1;
                    end
                end
            end

            for (int i = 0; i < NUN; i++) begin
                cls = 2'(i / UPC);
                if (!fu[i].ready) continue;
                if (fu[i].phase == PH_EXEC) begin
                    fu[i].phase = PH_DONE;
                    continue;
                end
                if (fu[i].phase != PH_DONE) continue;
                if (cls == CLS_LS && mem_busy) continue;
                sid = fu[i].station;
                fu[i].busy = 0;
                fu[i].ready = 0;
                fu[i].phase = PH_IDLE;
                rs[sid].busy = 0;
                rs[sid].got_unit = 0;
                rs[sid].first = 0;
                o.broadcasts++;
                if (rs[sid].has_dest) begin
                    for (int j = 0; j < NST; j++) begin
                        if (!rs[j].busy || rs[j].got_unit || !rs[j].renamed) continue;
                        for (int k = 0; k < 2; k++)
                            if (!rs[j].avail[k] && rs[j].src_tag[k] == sid + 1)
                                rs[j].avail[k] = 1;
                    end
                    if (reg_tag[rs[sid].dest] == sid + 1) reg_tag[rs[sid].dest] = '0;
                end
            end

            o.all_idle = !mem_busy;
            foreach (rs[i]) if (rs[i].busy) o.all_idle = 0;
            expected_ticks = {expected_ticks, o};
        endfunction

        function void check_result(tis_out_t got);
            tis_out_t exp_o;
            if (expected_ticks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            exp_o = expected_ticks.pop_front();
            if (got.issued !== exp_o.issued || got.stalled !== exp_o.stalled
                || got.register_reads !== exp_o.register_reads
                || got.broadcasts !== exp_o.broadcasts
                || got.request_kind !== exp_o.request_kind
                || got.request_address !== exp_o.request_address
                || got.request_count !== exp_o.request_count
                || got.all_idle !== exp_o.all_idle) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: expected %p actual %p", $realtime, exp_o, got);
            end
        endfunction
    endclass

    logic      aclk = 0;
    logic      aresetn;
    logic      s_valid, s_ready, m_valid, m_ready;
    tis_in_t   s_data;
    tis_out_t  m_data;
    logic      cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LAT_W-1:0]     cfg_data;

    tick_scoreboard sb = new();
    int snd_idle, rcv_idle;

    tomasulo_issue_scheduler #(.STATIONS_PER_CLASS(SPC), .UNITS_PER_CLASS(UPC)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_idle);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    task automatic send_tick(tis_in_t it);
        while ($urandom_range(99) < snd_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
    endtask

    task automatic drain();
        s_valid <= 0;
        do @(posedge aclk); while (sb.expected_ticks.size() != 0);
        repeat (80) @(posedge aclk);
    endtask

    // Caller lowers cfg_valid once the sequence is done.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LAT_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_latency(idx, val);
    endtask

    task automatic set_latencies(logic [7:0] l0, l1, l2, l3);
        write_reg(CFG_INT_LAT, l0);
        write_reg(CFG_DIV_LAT, l1);
        write_reg(CFG_MUL_LAT, l2);
        write_reg(CFG_MEM_LAT, l3);
        write_reg(3'($urandom_range(4, 7)), 8'($urandom));
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    function automatic tis_in_t mk(bit v, bit [4:0] op, bit [10:0] regs, bit [15:0] a, bit md);
        tis_in_t it;
        it.instr_valid = v;
        it.instr_word = {op, regs};
        it.access_address = a;
        it.memory_done = md;
        return it;
    endfunction

    function automatic tis_in_t rand_tick();
        bit [4:0] ops[14] = '{5'd0, 5'd1, OP_DIV, OP_MUL, OP_DIVU, OP_REM, OP_LOAD, OP_STORE,
                              OP_JR, OP_LI_FIRST, 5'd17, OP_LI_LAST, 5'd13, 5'd3};
        bit [4:0] op;
        op = ($urandom_range(99) < 80) ? ops[$urandom_range(13)] : 5'($urandom);
        return mk($urandom_range(99) < 85, op, 11'($urandom), 16'($urandom),
                  $urandom_range(99) < 35);
    endfunction

    initial begin
        logic [7:0] cfgs[6][4] = '{'{1, 1, 1, 1}, '{0, 0, 0, 0}, '{3, 7, 5, 2},
                                   '{255, 255, 255, 255}, '{1, 20, 9, 4}, '{2, 1, 1, 12}};
        aresetn <= 0;
        s_valid <= 0;
        s_data <= '0;
        m_ready <= 0;
        cfg_valid <= 0;
        cfg_index <= '0;
        cfg_data <= '0;
        snd_idle = 0;
        rcv_idle = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: chains through renaming, every class, memory round trips.
        set_latencies(1, 2, 3, 2);
        send_tick(mk(1, 5'd0, {3'd1, 3'd2, 3'd3, 2'd0}, 16'h0000, 0));
        send_tick(mk(1, 5'd1, {3'd2, 3'd1, 3'd1, 2'd3}, 16'hFFFF, 0));
        send_tick(mk(1, 5'd2, {3'd1, 3'd1, 3'd2, 2'd0}, 16'h0000, 0));
        send_tick(mk(1, 5'd3, {3'd7, 3'd7, 3'd7, 2'd3}, 16'h0000, 0));
        send_tick(mk(1, OP_DIV, {3'd0, 3'd1, 3'd2, 2'd0}, 16'h0000, 0));
        send_tick(mk(1, OP_MUL, {3'd3, 3'd0, 3'd0, 2'd0}, 16'h0000, 0));
        send_tick(mk(1, OP_LOAD, {3'd4, 3'd3, 3'd0, 2'd0}, 16'hFFFF, 0));
        send_tick(mk(1, OP_STORE, {3'd0, 3'd4, 3'd5, 2'd0}, 16'h8001, 0));
        send_tick(mk(1, OP_LOAD, {3'd6, 3'd6, 3'd0, 2'd0}, 16'h1234, 0));
        send_tick(mk(1, OP_DIVU, {3'd5, 3'd5, 3'd5, 2'd0}, 16'h0000, 1));
        send_tick(mk(1, OP_REM, {3'd6, 3'd0, 3'd0, 2'd0}, 16'h0000, 0));
        send_tick(mk(1, OP_JR, {3'd0, 3'd6, 3'd0, 2'd0}, 16'h0000, 1));
        send_tick(mk(1, OP_LI_FIRST, 11'h7FF, 16'h0000, 0));
        send_tick(mk(1, OP_LI_LAST, 11'h000, 16'h0000, 1));
        send_tick(mk(1, 5'd13, 11'h555, 16'h0000, 0));
        send_tick(mk(1, 5'd31, 11'h7FF, 16'hFFFF, 1));
        send_tick(mk(0, 5'd31, 11'h7FF, 16'hFFFF, 1));
        send_tick(mk(1, OP_STORE, 11'h000, 16'h0001, 1));
        send_tick(mk(0, 5'd0, 11'h000, 16'h0000, 1));
        send_tick(mk(0, 5'd0, 11'h000, 16'h0000, 0));
        send_tick(mk(0, 5'd0, 11'h000, 16'h0000, 1));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            snd_idle = (ph < 2) ? 15 : (ph < 4) ? 53 : 0;
            rcv_idle = (ph < 2) ? 53 : (ph < 4) ? 15 : 0;
            set_latencies(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2], cfgs[ph][3]);
            for (int n = 0; n < ((ph == 3) ? 100 : 220); n++) send_tick(rand_tick());
            // Leave units mid-flight so the next latency write lands during execution.
            s_valid <= 0;
            do @(posedge aclk); while (sb.expected_ticks.size() != 0);
            repeat (80) @(posedge aclk);
        end
        drain();

        if (sb.mismatches == 0 && sb.expected_ticks.size() == 0)
            $display("tb_tomasulo_issue_scheduler: PASS");
        else
            $display("tb_tomasulo_issue_scheduler: FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_tomasulo_issue_scheduler: FAIL");
        $finish;
    end

endmodule
